[src/bcpd_pkg.sv]
// ----------------------------------------------------------------------------
// bcpd_pkg
// Shared types, opcode codes and helpers for the bytecode predecoder.
// ----------------------------------------------------------------------------
package bcpd_pkg;

  // Widths
  localparam int ADDR_BITS  = 24;   // width of the incoming byte offset
  localparam int START_BITS = 24;   // width of the reported start offset
  localparam int NEXT_BITS  = 25;   // width of the reported next offset
  localparam int SIZE_BITS  = 25;   // width of the code size register
  localparam int WORD_BITS  = 32;   // operand word width

  // Opcode groups (high nibble)
  localparam logic [3:0] GRP_BINOP = 4'h0;
  localparam logic [3:0] GRP_BASIC = 4'h1;
  localparam logic [3:0] GRP_LD    = 4'h2;
  localparam logic [3:0] GRP_LDA   = 4'h3;
  localparam logic [3:0] GRP_ST    = 4'h4;
  localparam logic [3:0] GRP_CTRL  = 4'h5;
  localparam logic [3:0] GRP_PATT  = 4'h6;
  localparam logic [3:0] GRP_BUILT = 4'h7;
  localparam logic [3:0] GRP_STOP  = 4'hF;

  // Variants (low nibble) that matter for operand counts and flow
  localparam logic [3:0] VAR_CONST   = 4'h0;
  localparam logic [3:0] VAR_STRING  = 4'h1;
  localparam logic [3:0] VAR_SEXP    = 4'h2;
  localparam logic [3:0] VAR_JMP     = 4'h5;
  localparam logic [3:0] VAR_END     = 4'h6;
  localparam logic [3:0] VAR_RET     = 4'h7;
  localparam logic [3:0] VAR_CJMPZ   = 4'h0;
  localparam logic [3:0] VAR_CJMPNZ  = 4'h1;
  localparam logic [3:0] VAR_CLOSURE = 4'h4;
  localparam logic [3:0] VAR_CALL    = 4'h6;
  localparam logic [3:0] VAR_FAIL    = 4'h9;
  localparam logic [3:0] VAR_LINE    = 4'h8;
  localparam logic [3:0] VAR_TAG     = 4'hA;
  localparam logic [3:0] VAR_ARRAY   = 4'h4;

  // Highest capture kind byte
  localparam logic [7:0] KIND_MAX = 8'd3;

  // Flow kinds
  localparam logic [2:0] FLOW_SEQ  = 3'd0;
  localparam logic [2:0] FLOW_JMP  = 3'd1;
  localparam logic [2:0] FLOW_CJMP = 3'd2;
  localparam logic [2:0] FLOW_CALL = 3'd3;
  localparam logic [2:0] FLOW_END  = 3'd4;

  // Error codes
  localparam logic [1:0] ERR_OK     = 2'd0;
  localparam logic [1:0] ERR_BAD_OP = 2'd1;
  localparam logic [1:0] ERR_JUMP   = 2'd2;
  localparam logic [1:0] ERR_TARGET = 2'd3;

  // Register map
  localparam logic CFG_IDX_CODE_SIZE = 1'b0;

  // Decode phase
  typedef enum logic [1:0] {
    PH_OPCODE,
    PH_WORD,
    PH_KIND,
    PH_INDEX
  } phase_t;

  // What one byte does to the instruction in flight
  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_FINISH,
    ACT_FAIL_OP,
    ACT_FAIL_TGT
  } act_t;

  typedef struct packed {
    logic       ok;
    logic [1:0] words;
  } op_info_t;

  typedef struct packed {
    phase_t                  phase;
    logic [7:0]              opcode;
    logic [1:0]              word_idx;
    logic [1:0]              byte_idx;
    logic [23:0]             acc;        // low three bytes of the word
    logic [WORD_BITS-1:0]    caps_left;
    logic [START_BITS-1:0]   start;
    logic [WORD_BITS-1:0]    target;
    logic                    halted;
  } dec_state_t;

  typedef struct packed {
    logic [START_BITS-1:0] start_address;
    logic [NEXT_BITS-1:0]  next_address;
    logic [2:0]            flow_kind;
    logic [WORD_BITS-1:0]  target;
    logic                  has_target;
    logic [1:0]            error_code;
  } dec_result_t;

  // Operand word count of an opcode; ok low for an invalid opcode
  function automatic op_info_t op_words(input logic [7:0] opc);
    logic [3:0] h;
    logic [3:0] l;
    op_info_t   r;
    h = opc[7:4];
    l = opc[3:0];
    r = '{ok: 1'b0, words: 2'd0};
    case (h)
      GRP_BINOP: r.ok = (l >= 4'd1) && (l <= 4'd13);
      GRP_BASIC: begin
        r.ok = (l <= 4'd11);
        if (l == VAR_CONST || l == VAR_STRING || l == VAR_JMP) r.words = 2'd1;
        else if (l == VAR_SEXP)                                  r.words = 2'd2;
      end
      GRP_LD, GRP_LDA, GRP_ST: begin
        r.ok    = (l <= 4'd3);
        r.words = 2'd1;
      end
      GRP_CTRL: begin
        r.ok = (l <= 4'd10);
        if (l == VAR_CJMPZ || l == VAR_CJMPNZ || l == VAR_JMP ||
            l == VAR_LINE || l == VAR_TAG) r.words = 2'd1;
        else                               r.words = 2'd2;
      end
      GRP_PATT:  r.ok = (l <= 4'd6);
      GRP_BUILT: begin
        r.ok    = (l <= 4'd4);
        r.words = (l == VAR_ARRAY) ? 2'd1 : 2'd0;
      end
      GRP_STOP:  r.ok = 1'b1;
      default:   r.ok = 1'b0;
    endcase
    return r;
  endfunction

  // Target lies inside the code area (signed view)
  function automatic logic in_code(input logic [WORD_BITS-1:0] t,
                                   input logic [SIZE_BITS-1:0] size);
    return !t[WORD_BITS-1] && (t < WORD_BITS'(size));
  endfunction

endpackage

[src/bcpd_step.sv]
// ----------------------------------------------------------------------------
// bcpd_step
// Per-byte decode step: next decode state and the result an item causes.
// ----------------------------------------------------------------------------
module bcpd_step
  import bcpd_pkg::*;
(
  input  dec_state_t              cur,
  input  logic [7:0]              code_byte,
  input  logic [ADDR_BITS-1:0]    byte_address,
  input  logic [SIZE_BITS-1:0]    code_size,
  output dec_state_t              nxt,
  output logic                    emit,
  output dec_result_t             res
);

  logic [7:0]           opc_cur;
  logic [WORD_BITS-1:0] word_val;
  logic [WORD_BITS-1:0] tgt_cur;
  logic [WORD_BITS-1:0] caps_dec;
  logic                 word_end;
  logic                 is_closure;
  logic                 is_call;
  logic                 last_word;
  op_info_t             info;
  act_t                 act;
  logic [2:0]           fin_flow;
  logic                 fin_has;
  logic [1:0]           fin_err;

  // Operands seen by this byte
  assign opc_cur    = (cur.phase == PH_OPCODE) ? code_byte : cur.opcode;
  assign word_val   = {code_byte, cur.acc};
  assign word_end   = (cur.byte_idx == 2'd3);
  assign tgt_cur    = (cur.phase == PH_OPCODE) ? '0 :
                      (cur.phase == PH_WORD && word_end && cur.word_idx == 2'd0) ?
                      word_val : cur.target;
  assign caps_dec   = cur.caps_left - WORD_BITS'(1);
  assign info       = op_words(opc_cur);
  assign is_closure = (opc_cur[7:4] == GRP_CTRL) && (opc_cur[3:0] == VAR_CLOSURE);
  assign is_call    = (opc_cur[7:4] == GRP_CTRL) && (opc_cur[3:0] == VAR_CALL);
  assign last_word  = (3'({1'b0, cur.word_idx}) + 3'd1) >= 3'(info.words);

  // Action classifier
  always_comb begin
    act = ACT_NONE;
    if (!cur.halted) begin
      unique case (cur.phase)
        PH_OPCODE: begin
          if (!info.ok)               act = ACT_FAIL_OP;
          else if (info.words == 2'd0) act = ACT_FINISH;
        end
        PH_KIND: begin
          if (code_byte > KIND_MAX) act = ACT_FAIL_OP;
        end
        PH_WORD: begin
          if (word_end) begin
            if (is_closure && cur.word_idx != 2'd0) begin
              // capture count: none or negative ends the closure
              if (word_val[WORD_BITS-1] || word_val == '0) act = ACT_FINISH;
            end else if (is_closure && !in_code(word_val, code_size)) begin
              act = ACT_FAIL_TGT;
            end else if (last_word) begin
              if (is_call && !in_code(tgt_cur, code_size)) act = ACT_FAIL_TGT;
              else                                          act = ACT_FINISH;
            end
          end
        end
        PH_INDEX: begin
          if (word_end && caps_dec == '0) act = ACT_FINISH;
        end
        default: act = ACT_NONE;
      endcase
    end
  end

  // Next decode state
  always_comb begin
    nxt = cur;
    if (!cur.halted) begin
      unique case (cur.phase)
        PH_OPCODE: begin
          nxt.opcode = code_byte;
          nxt.start  = START_BITS'(byte_address);
          nxt.target = '0;
          if (act == ACT_NONE) begin
            nxt.word_idx = 2'd0;
            nxt.byte_idx = 2'd0;
            nxt.phase    = PH_WORD;
          end
        end
        PH_KIND: begin
          if (act == ACT_NONE) begin
            nxt.byte_idx = 2'd0;
            nxt.phase    = PH_INDEX;
          end
        end
        PH_WORD, PH_INDEX: begin
          case (cur.byte_idx)
            2'd0:    nxt.acc[7:0]   = code_byte;
            2'd1:    nxt.acc[15:8]  = code_byte;
            2'd2:    nxt.acc[23:16] = code_byte;
            default: nxt.acc        = cur.acc;
          endcase
          if (!word_end) begin
            nxt.byte_idx = cur.byte_idx + 2'd1;
          end else if (cur.phase == PH_INDEX) begin
            nxt.caps_left = caps_dec;
            nxt.byte_idx  = 2'd0;
            nxt.phase     = PH_KIND;
          end else begin
            nxt.byte_idx = 2'd0;
            if (cur.word_idx == 2'd0) nxt.target = word_val;
            if (is_closure && cur.word_idx != 2'd0) begin
              nxt.caps_left = word_val;
              nxt.phase     = PH_KIND;
            end else begin
              nxt.word_idx = cur.word_idx + 2'd1;
              nxt.phase    = PH_WORD;
            end
          end
        end
        default: nxt = cur;
      endcase
      // end of instruction, or halt
      if (act != ACT_NONE) nxt.phase = PH_OPCODE;
      if (act == ACT_FAIL_OP || act == ACT_FAIL_TGT) nxt.halted = 1'b1;
    end
  end

  // Flow, target presence and jump range check of a completed instruction
  always_comb begin
    fin_flow = FLOW_SEQ;
    fin_has  = 1'b0;
    if (opc_cur[7:4] == GRP_STOP) begin
      fin_flow = FLOW_END;
    end else if (opc_cur[7:4] == GRP_BASIC) begin
      if (opc_cur[3:0] == VAR_JMP) begin
        fin_flow = FLOW_JMP;
        fin_has  = 1'b1;
      end else if (opc_cur[3:0] inside {VAR_END, VAR_RET}) begin
        fin_flow = FLOW_END;
      end
    end else if (opc_cur[7:4] == GRP_CTRL) begin
      if (opc_cur[3:0] inside {VAR_CJMPZ, VAR_CJMPNZ}) begin
        fin_flow = FLOW_CJMP;
        fin_has  = 1'b1;
      end else if (opc_cur[3:0] == VAR_CALL) begin
        fin_flow = FLOW_CALL;
        fin_has  = 1'b1;
      end else if (opc_cur[3:0] == VAR_CLOSURE) begin
        fin_has  = 1'b1;
      end else if (opc_cur[3:0] == VAR_FAIL) begin
        fin_flow = FLOW_END;
      end
    end
    fin_err = ((fin_flow == FLOW_JMP || fin_flow == FLOW_CJMP) &&
               !in_code(tgt_cur, code_size)) ? ERR_JUMP : ERR_OK;
  end

  // Result fields
  always_comb begin
    emit               = (act != ACT_NONE);
    res.start_address  = (cur.phase == PH_OPCODE) ? START_BITS'(byte_address) : cur.start;
    res.next_address   = NEXT_BITS'({1'b0, byte_address} + (ADDR_BITS + 1)'(1));
    res.flow_kind      = FLOW_SEQ;
    res.target         = '0;
    res.has_target     = 1'b0;
    res.error_code     = ERR_OK;
    case (act)
      ACT_FAIL_OP: res.error_code = ERR_BAD_OP;
      ACT_FAIL_TGT: begin
        res.target     = tgt_cur;
        res.has_target = 1'b1;
        res.error_code = ERR_TARGET;
      end
      ACT_FINISH: begin
        res.flow_kind  = fin_flow;
        res.target     = fin_has ? tgt_cur : '0;
        res.has_target = fin_has;
        res.error_code = fin_err;
      end
      default: res.error_code = ERR_OK;
    endcase
  end

endmodule

[src/bytecode_instruction_predecoder.sv]
// ----------------------------------------------------------------------------
// bytecode_instruction_predecoder
// Byte-stream predecoder: finds instruction boundaries, flow kind and targets.
// ----------------------------------------------------------------------------
// Takes one code byte per cycle with its offset, unless stalled as below. Each accepted
// item lands in an input register; the decode step between that register and
// the result register advances the decode state by one byte; a result is
// registered and shown on out_valid when the step consumes the item carrying
// an instruction's last byte. Bytes completing no instruction keep flowing in
// while a result waits at the output; only a byte that would produce a second
// result stalls until the waiting one is taken. A bad opcode or capture kind,
// or a closure or call target outside [0, code_size), gives one error result
// and then the block swallows every further byte without result until reset.
// Write code_size through the APB port only while the block is idle.
// ----------------------------------------------------------------------------
module bytecode_instruction_predecoder
  import bcpd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // byte input
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_code_byte,
  input  logic [ADDR_BITS-1:0]  in_byte_address,
  // result output
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [START_BITS-1:0] out_start_address,
  output logic [NEXT_BITS-1:0]  out_next_address,
  output logic [2:0]            out_flow_kind,
  output logic signed [WORD_BITS-1:0] out_target,
  output logic                  out_has_target,
  output logic [1:0]            out_error_code,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic                  in_vld_r;
  logic [7:0]            in_byte_r;
  logic [ADDR_BITS-1:0]  in_addr_r;
  dec_state_t            state_r;
  dec_state_t            state_nxt;
  logic [SIZE_BITS-1:0]  code_size_r;
  logic                  out_vld_r;
  dec_result_t           out_r;
  dec_result_t           res;
  logic                  emit;
  logic                  proc_go;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == CFG_IDX_CODE_SIZE) ? 32'(code_size_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_size_r <= '0;
    end else if (psel && penable && pwrite && paddr[2] == CFG_IDX_CODE_SIZE) begin
      code_size_r <= pwdata[SIZE_BITS-1:0];
    end
  end

  // Decode step
  bcpd_step u_step (
    .cur          (state_r),
    .code_byte    (in_byte_r),
    .byte_address (in_addr_r),
    .code_size    (code_size_r),
    .nxt          (state_nxt),
    .emit         (emit),
    .res          (res)
  );

  // Handshake: a byte is consumed unless its result has nowhere to go
  assign proc_go  = in_vld_r && (!emit || !out_vld_r || out_ready);
  assign in_ready = !in_vld_r || proc_go;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_code_byte;
      in_addr_r <= in_byte_address;
    end
  end

  // Decode state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{phase: PH_OPCODE, opcode: '0, word_idx: '0, byte_idx: '0,
                   acc: '0, caps_left: '0, start: '0, target: '0, halted: 1'b0};
    end else if (proc_go) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (proc_go && emit) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_go && emit) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_start_address = out_r.start_address;
  assign out_next_address  = out_r.next_address;
  assign out_flow_kind     = out_r.flow_kind;
  assign out_target        = out_r.target;
  assign out_has_target    = out_r.has_target;
  assign out_error_code    = out_r.error_code;

  // Checks
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.halted |=> state_r.halted)
    else $error("halt state cleared without reset");

  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && state_r.halted |-> !emit)
    else $error("result produced while halted");

  a_halt_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_r.error_code == ERR_BAD_OP || out_r.error_code == ERR_TARGET)
    |-> out_r.flow_kind == FLOW_SEQ)
    else $error("halting error with non-sequential flow kind");

  a_no_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_r.has_target |-> out_r.target == '0)
    else $error("target reported without has_target");

endmodule

[verif/bytecode_instruction_predecoder_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bytecode_instruction_predecoder_tb
// Self-checking bench for the bytecode predecoder.
// ----------------------------------------------------------------------------
// Streams code bytes through the valid/ready input and predicts each decode
// result with a cycle-free model of the byte-level decode state machine held
// in a scoreboard object. Results are checked field by field in order. The
// code size register is rewritten between phases with the block drained:
// zero, one, both ends of its range and random values. A directed pass
// covers every group but LDA and the flow, target and capture-list corners;
// random phases then run well-formed instructions with random operands. The
// one halting error (bad opcode, bad capture kind, closure or call target
// outside the code) is saved for the very end, since only reset clears it,
// and is followed by bytes that must be swallowed.
// ----------------------------------------------------------------------------
module bytecode_instruction_predecoder_tb;
  import bcpd_pkg::*;

  localparam int          CYCLE_LIMIT    = 400000;
  localparam int          SETTLE_CYCLES  = 8;
  localparam logic [2:0]  CODE_SIZE_ADDR = {CFG_IDX_CODE_SIZE, 2'b00};
  localparam logic [24:0] SIZE_MAX       = 25'h1000000;

  // Scoreboard: decode predictor plus the queue of decodes still to come
  class decode_scoreboard;
    dec_result_t           expected_decodes[$];
    int unsigned           mismatches;
    logic [SIZE_BITS-1:0]  code_size;
    phase_t                phase;
    logic [7:0]            opcode;
    logic [1:0]            word_idx;
    logic [1:0]            byte_idx;
    logic [31:0]           acc;
    logic [31:0]           caps_left;
    logic [23:0]           start;
    logic [31:0]           target;
    bit                    halted;

    function new();
      mismatches = 0;
      code_size  = '0;
      phase      = PH_OPCODE;
      opcode     = '0;
      word_idx   = '0;
      byte_idx   = '0;
      acc        = '0;
      caps_left  = '0;
      start      = '0;
      target     = '0;
      halted     = 1'b0;
    endfunction

    // Operand words of an opcode, -1 for an invalid one
    static function int operand_words(logic [7:0] opc);
      logic [3:0] h;
      logic [3:0] l;
      h = opc[7:4];
      l = opc[3:0];
      case (h)
        GRP_BINOP: return (l >= 4'd1 && l <= 4'd13) ? 0 : -1;
        GRP_BASIC: begin
          if (l == VAR_CONST || l == VAR_STRING || l == VAR_JMP) return 1;
          if (l == VAR_SEXP) return 2;
          return (l <= 4'd11) ? 0 : -1;
        end
        GRP_LD, GRP_LDA, GRP_ST: return (l <= 4'd3) ? 1 : -1;
        GRP_CTRL: begin
          if (l == VAR_CJMPZ || l == VAR_CJMPNZ || l == VAR_JMP ||
              l == VAR_LINE || l == VAR_TAG) return 1;
          return (l <= 4'd9) ? 2 : -1;
        end
        GRP_PATT:  return (l <= 4'd6) ? 0 : -1;
        GRP_BUILT: begin
          if (l < VAR_ARRAY) return 0;
          return (l == VAR_ARRAY) ? 1 : -1;
        end
        GRP_STOP:  return 0;
        default:   return -1;
      endcase
    endfunction

    function bit target_in_code(logic [31:0] t);
      return !t[31] && (t < {7'b0, code_size});
    endfunction

    function void push_decode(logic [23:0] a, logic [2:0] flow, logic [31:0] t,
                              bit has, logic [1:0] err);
      dec_result_t r;
      r.start_address = start;
      r.next_address  = {1'b0, a} + 25'd1;
      r.flow_kind     = flow;
      r.target        = has ? t : '0;
      r.has_target    = has;
      r.error_code    = err;
      expected_decodes = {expected_decodes, r};
      phase = PH_OPCODE;
    endfunction

    function void abort_instr(logic [23:0] a, logic [1:0] err, logic [31:0] t, bit has);
      halted = 1'b1;
      push_decode(a, FLOW_SEQ, t, has, err);
    endfunction

    // Flow kind and target flag from the opcode, jump range flag
    function void complete_instr(logic [23:0] a);
      logic [3:0] h;
      logic [3:0] l;
      logic [2:0] flow;
      bit         has;
      logic [1:0] err;
      h    = opcode[7:4];
      l    = opcode[3:0];
      flow = FLOW_SEQ;
      has  = 1'b0;
      err  = ERR_OK;
      if (h == GRP_STOP) flow = FLOW_END;
      else if (h == GRP_BASIC && l == VAR_JMP) begin
        flow = FLOW_JMP;
        has  = 1'b1;
      end else if (h == GRP_BASIC && (l == VAR_END || l == VAR_RET)) flow = FLOW_END;
      else if (h == GRP_CTRL && (l == VAR_CJMPZ || l == VAR_CJMPNZ)) begin
        flow = FLOW_CJMP;
        has  = 1'b1;
      end else if (h == GRP_CTRL && l == VAR_CALL) begin
        flow = FLOW_CALL;
        has  = 1'b1;
      end else if (h == GRP_CTRL && l == VAR_CLOSURE) has = 1'b1;
      else if (h == GRP_CTRL && l == VAR_FAIL) flow = FLOW_END;
      if ((flow == FLOW_JMP || flow == FLOW_CJMP) && !target_in_code(target)) err = ERR_JUMP;
      push_decode(a, flow, target, has, err);
    endfunction

    function void open_word(phase_t p);
      phase    = p;
      byte_idx = '0;
      acc      = '0;
    endfunction

    // A full little-endian word has arrived
    function void word_done(logic [23:0] a);
      logic [3:0]  h;
      logic [3:0]  l;
      logic [31:0] v;
      h = opcode[7:4];
      l = opcode[3:0];
      v = acc;
      if (phase == PH_INDEX) begin
        caps_left = caps_left - 32'd1;
        if (caps_left == 0) complete_instr(a);
        else open_word(PH_KIND);
        return;
      end
      if (word_idx == 0) target = v;
      if (h == GRP_CTRL && l == VAR_CLOSURE) begin
        if (word_idx == 0) begin
          if (!target_in_code(v)) begin
            abort_instr(a, ERR_TARGET, v, 1'b1);
            return;
          end
        end else begin
          // non-positive capture count closes the instruction here
          if (v[31] || v == 0) complete_instr(a);
          else begin
            caps_left = v;
            open_word(PH_KIND);
          end
          return;
        end
      end
      if (int'(word_idx) + 1 >= operand_words(opcode)) begin
        if (h == GRP_CTRL && l == VAR_CALL && !target_in_code(target))
          abort_instr(a, ERR_TARGET, target, 1'b1);
        else
          complete_instr(a);
        return;
      end
      word_idx = word_idx + 2'd1;
      open_word(PH_WORD);
    endfunction

    // Accepted input item
    function void note_byte(logic [7:0] b, logic [23:0] a);
      int n;
      if (halted) return;
      case (phase)
        PH_OPCODE: begin
          n      = operand_words(b);
          opcode = b;
          start  = a;
          target = '0;
          if (n < 0) abort_instr(a, ERR_BAD_OP, '0, 1'b0);
          else if (n == 0) complete_instr(a);
          else begin
            word_idx = '0;
            open_word(PH_WORD);
          end
        end
        PH_KIND: begin
          if (b > KIND_MAX) abort_instr(a, ERR_BAD_OP, '0, 1'b0);
          else open_word(PH_INDEX);
        end
        default: begin
          acc = acc | (32'(b) << (8 * byte_idx));
          if (byte_idx < 2'd3) byte_idx = byte_idx + 2'd1;
          else word_done(a);
        end
      endcase
    endfunction

    task report(string what, logic [31:0] want, logic [31:0] got);
      $display("%0t mismatch %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
      mismatches++;
    endtask

    // Accepted result item against the oldest prediction
    task check_decode(dec_result_t got);
      dec_result_t want;
      if (expected_decodes.size() == 0) begin
        report("result with none pending", 0, 32'(got.start_address));
        return;
      end
      want = expected_decodes.pop_front();
      if (got.start_address != want.start_address)
        report("start_address", 32'(want.start_address), 32'(got.start_address));
      if (got.next_address != want.next_address)
        report("next_address", 32'(want.next_address), 32'(got.next_address));
      if (got.flow_kind != want.flow_kind)
        report("flow_kind", 32'(want.flow_kind), 32'(got.flow_kind));
      if (got.target != want.target)
        report("target", want.target, got.target);
      if (got.has_target != want.has_target)
        report("has_target", 32'(want.has_target), 32'(got.has_target));
      if (got.error_code != want.error_code)
        report("error_code", 32'(want.error_code), 32'(got.error_code));
    endtask
  endclass

  logic                        clk             = 1'b0;
  logic                        rst_n           = 1'b0;
  logic                        in_valid        = 1'b0;
  logic                        in_ready;
  logic [7:0]                  in_code_byte    = '0;
  logic [ADDR_BITS-1:0]        in_byte_address = '0;
  logic                        out_valid;
  logic                        out_ready       = 1'b0;
  logic [START_BITS-1:0]       out_start_address;
  logic [NEXT_BITS-1:0]        out_next_address;
  logic [2:0]                  out_flow_kind;
  logic signed [WORD_BITS-1:0] out_target;
  logic                        out_has_target;
  logic [1:0]                  out_error_code;
  logic                        psel            = 1'b0;
  logic                        penable         = 1'b0;
  logic                        pwrite          = 1'b0;
  logic [2:0]                  paddr           = '0;
  logic [31:0]                 pwdata          = '0;
  logic [31:0]                 prdata;
  logic                        pready;

  decode_scoreboard sb = new();

  logic [23:0] next_addr     = '0;
  logic [24:0] code_size_now = '0;
  bit          calm          = 1'b0;
  logic [7:0]  instr_bytes[$];
  int          stim_count    = 0;
  int          stall_left    = 0;
  int          ready_roll;
  int          cycles        = 0;

  bytecode_instruction_predecoder dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_code_byte      (in_code_byte),
    .in_byte_address   (in_byte_address),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_start_address (out_start_address),
    .out_next_address  (out_next_address),
    .out_flow_kind     (out_flow_kind),
    .out_target        (out_target),
    .out_has_target    (out_has_target),
    .out_error_code    (out_error_code),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #5 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side back-pressure: short stalls mostly, the odd long one
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if (!calm) begin
        ready_roll = $urandom_range(0, 99);
        if (ready_roll < 12) stall_left = $urandom_range(1, 3);
        else if (ready_roll < 15) stall_left = $urandom_range(8, 30);
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin : result_monitor
    dec_result_t seen;
    if (rst_n && out_valid && out_ready) begin
      seen.start_address = out_start_address;
      seen.next_address  = out_next_address;
      seen.flow_kind     = out_flow_kind;
      seen.target        = out_target;
      seen.has_target    = out_has_target;
      seen.error_code    = out_error_code;
      sb.check_decode(seen);
    end
  end

  // Random operand word with a bias to the edges
  function automatic logic [31:0] pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 32'h0;
    if (r < 20) return 32'hFFFF_FFFF;
    if (r < 25) return 32'h8000_0000;
    return $urandom;
  endfunction

  // Target inside the current code area (size known to be non-zero)
  function automatic logic [31:0] pick_code_target();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 32'h0;
    if (r < 30) return 32'(code_size_now) - 32'd1;
    return $urandom_range(0, 32'(code_size_now) - 32'd1);
  endfunction

  function automatic logic [31:0] pick_outside_target();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 32'(code_size_now);
    if (r < 60) return 32'hFFFF_FFFF;
    if (r < 80) return 32'h8000_0000;
    return {1'b1, 31'($urandom)};
  endfunction

  // Jump targets land either side of the range edges
  function automatic logic [31:0] pick_jump_target();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50 && code_size_now != 0) return pick_code_target();
    if (r < 60) return 32'(code_size_now);
    if (r < 70 && code_size_now != 0) return 32'(code_size_now) - 32'd1;
    if (r < 80) return {1'b1, 31'($urandom)};
    if (r < 85) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // Valid opcode, flow instructions favoured; no call or closure without code
  function automatic logic [7:0] pick_opcode();
    logic [7:0] opc;
    int         r;
    r = $urandom_range(0, 99);
    if (r < 6) opc = {GRP_BASIC, VAR_JMP};
    else if (r < 12) opc = {GRP_CTRL, VAR_CJMPZ};
    else if (r < 18) opc = {GRP_CTRL, VAR_CJMPNZ};
    else if (r < 26) opc = {GRP_CTRL, VAR_CALL};
    else if (r < 34) opc = {GRP_CTRL, VAR_CLOSURE};
    else begin
      opc = 8'($urandom_range(0, 255));
      while (decode_scoreboard::operand_words(opc) < 0) opc = 8'($urandom_range(0, 255));
    end
    if (code_size_now == 0 && opc[7:4] == GRP_CTRL &&
        (opc[3:0] == VAR_CALL || opc[3:0] == VAR_CLOSURE))
      opc = {GRP_STOP, 4'($urandom_range(0, 15))};
    return opc;
  endfunction

  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 78) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic put_byte(logic [7:0] b);
    instr_bytes = {instr_bytes, b};
  endtask

  task automatic put_word(logic [31:0] w);
    put_byte(w[7:0]);
    put_byte(w[15:8]);
    put_byte(w[23:16]);
    put_byte(w[31:24]);
  endtask

  // One input item; valid stays up unless a gap follows
  task automatic send_byte(logic [7:0] b);
    int g;
    @(negedge clk);
    in_valid        <= 1'b1;
    in_code_byte    <= b;
    in_byte_address <= next_addr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_byte(b, next_addr);
    next_addr = next_addr + 24'd1;
    stim_count++;
    g = gap_len();
    if (g > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  task automatic send_instr();
    foreach (instr_bytes[i]) send_byte(instr_bytes[i]);
    instr_bytes.delete();
  endtask

  task automatic direct(logic [7:0] opc, int nwords, logic [31:0] w0, logic [31:0] w1);
    put_byte(opc);
    if (nwords > 0) put_word(w0);
    if (nwords > 1) put_word(w1);
    send_instr();
  endtask

  // Well-formed instruction with random operands
  task automatic build_instr(logic [7:0] opc);
    logic [3:0]  h;
    logic [3:0]  l;
    logic [31:0] cnt;
    int          n;
    int          r;
    h = opc[7:4];
    l = opc[3:0];
    put_byte(opc);
    if (h == GRP_CTRL && l == VAR_CLOSURE) begin
      put_word(pick_code_target());
      r = $urandom_range(0, 99);
      if (r < 12) cnt = 32'h0;
      else if (r < 22) cnt = {1'b1, 31'($urandom)};
      else cnt = $urandom_range(1, 4);
      put_word(cnt);
      if (!cnt[31]) begin
        repeat (cnt) begin
          put_byte(8'($urandom_range(0, KIND_MAX)));
          put_word(pick_word());
        end
      end
    end else begin
      n = decode_scoreboard::operand_words(opc);
      for (int i = 0; i < n; i++) begin
        if (i == 0 && ((h == GRP_BASIC && l == VAR_JMP) ||
                       (h == GRP_CTRL && (l == VAR_CJMPZ || l == VAR_CJMPNZ))))
          put_word(pick_jump_target());
        else if (i == 0 && h == GRP_CTRL && l == VAR_CALL)
          put_word(pick_code_target());
        else
          put_word(pick_word());
      end
    end
  endtask

  // Drop valid, wait for every pending decode, then let the pipe empty
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_decodes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Code size write followed by a read-back
  task automatic set_code_size(logic [24:0] v);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CODE_SIZE_ADDR;
    pwdata  <= 32'(v);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    code_size_now = v;
    sb.code_size  = v;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata != 32'(v)) sb.report("code_size read-back", 32'(v), prdata);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Random phase under one code size, with one full drain half way
  task automatic run_phase(logic [24:0] size, bit quiet, int nbytes);
    int  stop_at;
    bit  paused;
    settle();
    set_code_size(size);
    calm    = quiet;
    stop_at = stim_count + nbytes;
    paused  = 1'b0;
    while (stim_count < stop_at) begin
      if ($urandom_range(0, 99) < 3) next_addr = 24'($urandom);
      build_instr(pick_opcode());
      send_instr();
      if (!paused && stim_count >= stop_at - nbytes / 2) begin
        paused = 1'b1;
        settle();
      end
    end
  endtask

  initial begin
    logic [7:0] bad_op;
    int         pick;
    int         caps;
    int         bad_at;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed pass, full 16 MiB code area
    set_code_size(SIZE_MAX);
    next_addr = 24'hFF_FFFF;
    direct({GRP_STOP, 4'h0}, 0, 0, 0);                  // last offset, next carries into bit 24
    direct({GRP_BINOP, 4'd1}, 0, 0, 0);
    direct({GRP_BINOP, 4'd13}, 0, 0, 0);
    direct({GRP_BASIC, VAR_CONST}, 1, 32'hFFFF_FFFF, 0);
    direct({GRP_BASIC, VAR_STRING}, 1, 32'h0, 0);
    direct({GRP_BASIC, VAR_SEXP}, 2, 32'h1234_5678, 32'h8000_0000);
    direct({GRP_BASIC, 4'd11}, 0, 0, 0);
    direct({GRP_BASIC, VAR_END}, 0, 0, 0);
    direct({GRP_BASIC, VAR_RET}, 0, 0, 0);
    direct({GRP_LD, 4'd0}, 1, 32'd7, 0);
    direct({GRP_ST, 4'd3}, 1, 32'hA5A5_5A5A, 0);
    direct({GRP_BASIC, VAR_JMP}, 1, 32'h0, 0);
    direct({GRP_BASIC, VAR_JMP}, 1, 32'h00FF_FFFF, 0);   // last byte of the code
    direct({GRP_BASIC, VAR_JMP}, 1, 32'h0100_0000, 0);   // one past the end: flagged only
    direct({GRP_CTRL, VAR_CJMPZ}, 1, 32'h8000_0000, 0);  // negative target
    direct({GRP_CTRL, VAR_CJMPNZ}, 1, 32'hFFFF_FFFF, 0);
    direct({GRP_CTRL, VAR_CALL}, 2, 32'h00FF_FFFF, 32'd3);
    direct({GRP_CTRL, VAR_CLOSURE}, 2, 32'h0, 32'h0);    // zero captures
    direct({GRP_CTRL, VAR_CLOSURE}, 2, 32'd16, 32'hFFFF_FFFF); // negative count
    put_byte({GRP_CTRL, VAR_CLOSURE});                   // two captures, lowest and highest kind
    put_word(32'h00FF_FFFF);
    put_word(32'd2);
    put_byte(8'd0);
    put_word(32'd5);
    put_byte(KIND_MAX);
    put_word(32'hFFFF_FFFF);
    send_instr();
    direct({GRP_CTRL, 4'd2}, 2, 32'h1, 32'h2);
    direct({GRP_CTRL, VAR_LINE}, 1, 32'd42, 0);
    direct({GRP_CTRL, VAR_FAIL}, 2, 32'h0, 32'hFFFF_FFFF);
    direct({GRP_CTRL, VAR_TAG}, 1, 32'h8000_0001, 0);
    direct({GRP_PATT, 4'd6}, 0, 0, 0);
    direct({GRP_BUILT, VAR_ARRAY}, 1, 32'd9, 0);
    direct({GRP_STOP, 4'hF}, 0, 0, 0);

    // Random phases across the code size range
    run_phase(25'd0, 1'b0, 220);
    run_phase(25'd1, 1'b1, 220);
    run_phase(SIZE_MAX - 25'd1, 1'b0, 220);
    run_phase(25'($urandom_range(2, 64)), 1'b0, 220);
    run_phase(25'($urandom_range(2, SIZE_MAX)), 1'b0, 220);
    run_phase(25'($urandom_range(1, SIZE_MAX)), 1'b0, 120);

    // One halting error, then bytes the block has to swallow
    pick = $urandom_range(0, 3);
    case (pick)
      0: begin
        bad_op = 8'($urandom_range(0, 255));
        while (decode_scoreboard::operand_words(bad_op) >= 0)
          bad_op = 8'($urandom_range(0, 255));
        put_byte(bad_op);
      end
      1: begin
        caps   = $urandom_range(1, 3);
        bad_at = $urandom_range(0, caps - 1);
        put_byte({GRP_CTRL, VAR_CLOSURE});
        put_word(pick_code_target());
        put_word(32'(caps));
        repeat (bad_at) begin
          put_byte(8'($urandom_range(0, KIND_MAX)));
          put_word(pick_word());
        end
        put_byte(8'($urandom_range(KIND_MAX + 1, 255)));
      end
      2: begin
        put_byte({GRP_CTRL, VAR_CLOSURE});
        put_word(pick_outside_target());
      end
      default: begin
        put_byte({GRP_CTRL, VAR_CALL});
        put_word(pick_outside_target());
        put_word(pick_word());
      end
    endcase
    send_instr();
    repeat (24) send_byte(8'($urandom_range(0, 255)));

    settle();
    if (sb.mismatches == 0 && sb.expected_decodes.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

[files.f]
src/bcpd_pkg.sv
src/bcpd_step.sv
src/bytecode_instruction_predecoder.sv
verif/bytecode_instruction_predecoder_tb.sv
